// ===== rtl/bts_pkg.sv =====
// Shared constants and types for the bilinear texture sampler.
package bts_pkg;
  localparam int COLOR_W    = 16;
  localparam int COORD_W    = 20;
  localparam int FRAC_W     = 16;
  localparam int ADDR_W     = 16;
  localparam int DIM_W      = 9;
  localparam int IDX_W      = 8;
  localparam int MAX_DIM    = 256;
  localparam int UCL_W      = FRAC_W + 1;
  localparam int POS_W      = UCL_W + IDX_W;
  localparam int ROW_W      = IDX_W + DIM_W;
  localparam int WT_W       = FRAC_W + 1;
  localparam int ROWSUM_W   = COLOR_W + WT_W;
  localparam int FINAL_W    = ROWSUM_W + WT_W + 1;
  localparam int TEXEL_W    = 3 * COLOR_W + 1;

  localparam logic       OP_WRITE  = 1'b0;
  localparam logic       OP_SAMPLE = 1'b1;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic [UCL_W-1:0] ONE_COORD = UCL_W'(1) << FRAC_W;
  localparam logic [WT_W-1:0]  ONE_WT    = WT_W'(1) << FRAC_W;

  typedef logic [TEXEL_W-1:0] texel_t;
  typedef logic [COLOR_W-1:0] color_t;
endpackage

// ===== rtl/bilinear_texture_sampler_unit.sv =====
// Top level: pipelined bilinear texture sampler with a replicated texel store.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid/in_ready   | opcode texel_index texel_* u_coord v_coord
//  out     | out_valid/out_ready | red_out green_out blue_out invalid_out
//  cfg     | cfg_valid/cfg_ready | cfg_index cfg_data
//
// One beat per cycle in each direction while the pipe is not stalled. Seven register
// stages, the first loaded on the edge that takes the input beat: clamp, scale, row
// multiply, address add, store read, row blend, column blend into the output
// register. Write beats flow through and produce nothing. The whole pipe advances
// when the output register is empty or taken, so a stall holds every stage. Sync
// reset clears valid bits and config registers; the texel store is not cleared.
// cfg_ready is always high.
module bilinear_texture_sampler_unit
  import bts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic [ADDR_W-1:0]         texel_index,
  input  logic [COLOR_W-1:0]        texel_red,
  input  logic [COLOR_W-1:0]        texel_green,
  input  logic [COLOR_W-1:0]        texel_blue,
  input  logic                      texel_invalid,
  input  logic signed [COORD_W-1:0] u_coord,
  input  logic signed [COORD_W-1:0] v_coord,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COLOR_W-1:0]        red_out,
  output logic [COLOR_W-1:0]        green_out,
  output logic [COLOR_W-1:0]        blue_out,
  output logic                      invalid_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [DIM_W-1:0]          cfg_data
);

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // config
  logic [DIM_W-1:0] texture_width, texture_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      texture_width  <= '0;
      texture_height <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  texture_width  <= cfg_data;
        REG_HEIGHT: texture_height <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [UCL_W-1:0] clamp(input logic [COORD_W-1:0] c);
    logic [UCL_W-1:0] r;
    if (c[COORD_W-1])                          r = '0;
    else if (c > COORD_W'(ONE_COORD))          r = ONE_COORD;
    else                                       r = c[UCL_W-1:0];
    return r;
  endfunction

  logic [DIM_W-1:0] ws, hs;
  assign ws = (texture_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : texture_width;
  assign hs = (texture_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : texture_height;

  // stage 1: clamp
  logic               v1, op1, blank1, inv1;
  logic [ADDR_W-1:0]  idx1;
  color_t             r1, g1, b1;
  logic [UCL_W-1:0]   u1, vv1;
  logic [IDX_W-1:0]   wm1, hm1;
  logic [DIM_W-1:0]   w1;
  always_ff @(posedge clk) begin
    if (rst)      v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      op1    <= opcode;
      idx1   <= texel_index;
      r1     <= texel_red;
      g1     <= texel_green;
      b1     <= texel_blue;
      inv1   <= texel_invalid;
      u1     <= clamp(u_coord);
      vv1    <= clamp(v_coord);
      w1     <= ws;
      wm1    <= IDX_W'(ws - DIM_W'(1));
      hm1    <= IDX_W'(hs - DIM_W'(1));
      blank1 <= (ws == '0) || (hs == '0);
    end
  end

  // stage 2: scale by size-1
  logic               v2, op2, blank2, inv2;
  logic [ADDR_W-1:0]  idx2;
  color_t             r2, g2, b2;
  logic [POS_W-1:0]   xp2, yp2;
  logic [DIM_W-1:0]   w2;
  always_ff @(posedge clk) begin
    if (rst)      v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      op2 <= op1; idx2 <= idx1; r2 <= r1; g2 <= g1; b2 <= b1; inv2 <= inv1;
      blank2 <= blank1; w2 <= w1;
      xp2 <= POS_W'(u1) * POS_W'(wm1);
      yp2 <= POS_W'(vv1) * POS_W'(hm1);
    end
  end

  // stage 3: row offsets
  logic               v3, op3, blank3, inv3;
  logic [ADDR_W-1:0]  idx3;
  color_t             r3, g3, b3;
  logic [IDX_W-1:0]   x0_3, x1_3;
  logic [ROW_W-1:0]   row0_3, row1_3;
  logic [FRAC_W-1:0]  fx3, fy3;
  logic [IDX_W-1:0]   y0, y1;
  assign y0 = yp2[FRAC_W +: IDX_W];
  assign y1 = y0 + IDX_W'(yp2[FRAC_W-1:0] != '0);
  always_ff @(posedge clk) begin
    if (rst)      v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      op3 <= op2; idx3 <= idx2; r3 <= r2; g3 <= g2; b3 <= b2; inv3 <= inv2;
      blank3 <= blank2;
      x0_3   <= xp2[FRAC_W +: IDX_W];
      x1_3   <= xp2[FRAC_W +: IDX_W] + IDX_W'(xp2[FRAC_W-1:0] != '0);
      fx3    <= xp2[FRAC_W-1:0];
      fy3    <= yp2[FRAC_W-1:0];
      row0_3 <= ROW_W'(y0) * ROW_W'(w2);
      row1_3 <= ROW_W'(y1) * ROW_W'(w2);
    end
  end

  // stage 4: addresses (write beats use texel_index on port a0)
  logic               v4, op4, blank4;
  texel_t             wd4;
  logic [ADDR_W-1:0]  a0, a1, a2, a3;
  logic [FRAC_W-1:0]  fx4, fy4;
  always_ff @(posedge clk) begin
    if (rst)      v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      op4 <= op3; blank4 <= blank3; fx4 <= fx3; fy4 <= fy3;
      wd4 <= {inv3, b3, g3, r3};
      a0  <= (op3 == OP_WRITE) ? idx3 : ADDR_W'(row0_3 + ROW_W'(x0_3));
      a1  <= ADDR_W'(row0_3 + ROW_W'(x1_3));
      a2  <= ADDR_W'(row1_3 + ROW_W'(x0_3));
      a3  <= ADDR_W'(row1_3 + ROW_W'(x1_3));
    end
  end

  // stage 5: two copies of the store, two read ports each
  texel_t mem_a [2**ADDR_W];
  texel_t mem_b [2**ADDR_W];
  texel_t t0, t1, t2, t3;
  logic               v5, op5, blank5;
  logic [FRAC_W-1:0]  fx5, fy5;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v4 && op4 == OP_WRITE) begin
        mem_a[a0] <= wd4;
      end
      t0 <= mem_a[a0];
      t1 <= mem_a[a1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v4 && op4 == OP_WRITE) begin
        mem_b[a0] <= wd4;
      end
      t2 <= mem_b[a2];
      t3 <= mem_b[a3];
    end
  end
  always_ff @(posedge clk) begin
    if (rst)      v5 <= 1'b0;
    else if (adv) v5 <= v4;
    if (adv) begin
      op5 <= op4; blank5 <= blank4; fx5 <= fx4; fy5 <= fy4;
    end
  end

  // stage 6: horizontal blend per row
  logic                v6, op6, blank6, inv6;
  logic [WT_W-1:0]     fy6;
  logic [ROWSUM_W-1:0] top6 [3];
  logic [ROWSUM_W-1:0] bot6 [3];
  logic [WT_W-1:0]     fxw, fxc;
  assign fxw = WT_W'(fx5);
  assign fxc = ONE_WT - fxw;
  always_ff @(posedge clk) begin
    if (rst)      v6 <= 1'b0;
    else if (adv) v6 <= v5;
    if (adv) begin
      op6 <= op5; blank6 <= blank5; fy6 <= WT_W'(fy5);
      inv6 <= t0[TEXEL_W-1] | t1[TEXEL_W-1] | t2[TEXEL_W-1] | t3[TEXEL_W-1];
      for (int k = 0; k < 3; k++) begin
        top6[k] <= ROWSUM_W'(t1[k*COLOR_W +: COLOR_W]) * ROWSUM_W'(fxw)
                 + ROWSUM_W'(t0[k*COLOR_W +: COLOR_W]) * ROWSUM_W'(fxc);
        bot6[k] <= ROWSUM_W'(t3[k*COLOR_W +: COLOR_W]) * ROWSUM_W'(fxw)
                 + ROWSUM_W'(t2[k*COLOR_W +: COLOR_W]) * ROWSUM_W'(fxc);
      end
    end
  end

  // stage 7: vertical blend into output register
  logic [FINAL_W-1:0] fin [3];
  logic               kill;
  assign kill = blank6 | inv6;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fin[k] = FINAL_W'(bot6[k]) * FINAL_W'(fy6)
             + FINAL_W'(top6[k]) * FINAL_W'(ONE_WT - fy6);
    end
  end
  always_ff @(posedge clk) begin
    if (rst)      out_valid <= 1'b0;
    else if (adv) out_valid <= v6 && (op6 == OP_SAMPLE);
    if (adv) begin
      red_out     <= kill ? '0 : fin[0][2*FRAC_W +: COLOR_W];
      green_out   <= kill ? '0 : fin[1][2*FRAC_W +: COLOR_W];
      blue_out    <= kill ? '0 : fin[2][2*FRAC_W +: COLOR_W];
      invalid_out <= inv6 & ~blank6;
    end
  end

endmodule

// ===== rtl/bts_checker.sv =====
// Port-level checks for the texture sampler, bound to the top level.
module bts_props
  import bts_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] red_out,
  input logic [COLOR_W-1:0] green_out,
  input logic [COLOR_W-1:0] blue_out,
  input logic               invalid_out
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped during stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output space");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid_out |-> red_out == '0 && green_out == '0 && blue_out == '0)
    else $error("invalid result carries color");
endmodule

bind bilinear_texture_sampler_unit bts_props u_bts_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .red_out(red_out), .green_out(green_out),
  .blue_out(blue_out), .invalid_out(invalid_out)
);

// ===== tb/bts_checker.sv =====
// Beat monitor, texel store mirror and result scoreboard for the texture sampler.
module bts_checker
  import bts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      opcode,
  input  logic [ADDR_W-1:0]         texel_index,
  input  logic [COLOR_W-1:0]        texel_red,
  input  logic [COLOR_W-1:0]        texel_green,
  input  logic [COLOR_W-1:0]        texel_blue,
  input  logic                      texel_invalid,
  input  logic signed [COORD_W-1:0] u_coord,
  input  logic signed [COORD_W-1:0] v_coord,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [COLOR_W-1:0]        red_out,
  input  logic [COLOR_W-1:0]        green_out,
  input  logic [COLOR_W-1:0]        blue_out,
  input  logic                      invalid_out,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [DIM_W-1:0]          cfg_data,
  output int                        fail_count,
  output int                        samples_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
    logic   bad;
  } pixel_t;

  texel_t          texels [0:(1<<ADDR_W)-1];  // {bad, red, green, blue}
  logic [DIM_W-1:0] tex_w;
  logic [DIM_W-1:0] tex_h;
  pixel_t          pixels_due [$];

  function automatic longint unsigned clamp_uv(logic [COORD_W-1:0] c);
    if (c[COORD_W-1]) return 0;
    if (c > (1 << FRAC_W)) return 1 << FRAC_W;
    return c;
  endfunction

  function automatic pixel_t filter_at(logic [COORD_W-1:0] uc, logic [COORD_W-1:0] vc);
    longint unsigned w, h, xp, yp, x0, x1, y0, y1, fx, fy, top, bot, val;
    texel_t t00, t01, t10, t11;
    pixel_t px;
    px = '0;
    w = (tex_w > MAX_DIM) ? MAX_DIM : tex_w;
    h = (tex_h > MAX_DIM) ? MAX_DIM : tex_h;
    if (w == 0 || h == 0) return px;
    xp = clamp_uv(uc) * (w - 1);
    yp = clamp_uv(vc) * (h - 1);
    x0 = xp >> FRAC_W;
    y0 = yp >> FRAC_W;
    fx = xp & 64'hFFFF;
    fy = yp & 64'hFFFF;
    x1 = (fx != 0) ? x0 + 1 : x0;
    y1 = (fy != 0) ? y0 + 1 : y0;
    t00 = texels[ADDR_W'(y0 * w + x0)];
    t01 = texels[ADDR_W'(y0 * w + x1)];
    t10 = texels[ADDR_W'(y1 * w + x0)];
    t11 = texels[ADDR_W'(y1 * w + x1)];
    if (t00[TEXEL_W-1] | t01[TEXEL_W-1] | t10[TEXEL_W-1] | t11[TEXEL_W-1]) begin
      px.bad = 1'b1;
      return px;
    end
    for (int k = 0; k < 3; k++) begin
      // channel k sits at bits [47-16k -: 16]
      top = longint'(t01[47-16*k -: 16]) * fx + longint'(t00[47-16*k -: 16]) * (65536 - fx);
      bot = longint'(t11[47-16*k -: 16]) * fx + longint'(t10[47-16*k -: 16]) * (65536 - fx);
      val = (bot * fy + top * (65536 - fy)) >> 32;
      if (k == 0) px.red = val[15:0];
      else if (k == 1) px.green = val[15:0];
      else px.blue = val[15:0];
    end
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      tex_w = '0;
      tex_h = '0;
      pixels_due.delete();
      fail_count = 0;
      samples_due = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) tex_w = cfg_data;
        else if (cfg_index == REG_HEIGHT) tex_h = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (opcode == OP_WRITE)
          texels[texel_index] = {texel_invalid, texel_red, texel_green, texel_blue};
        else
          pixels_due.push_back(filter_at(u_coord, v_coord));
      end
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = pixels_due.pop_front();
          if (red_out !== want.red) begin
            $error("red_out: expected %0d, got %0d", want.red, red_out); fail_count++;
          end
          if (green_out !== want.green) begin
            $error("green_out: expected %0d, got %0d", want.green, green_out); fail_count++;
          end
          if (blue_out !== want.blue) begin
            $error("blue_out: expected %0d, got %0d", want.blue, blue_out); fail_count++;
          end
          if (invalid_out !== want.bad) begin
            $error("invalid_out: expected %0d, got %0d", want.bad, invalid_out); fail_count++;
          end
        end
      end
      samples_due = pixels_due.size();
    end
  end
endmodule

// ===== tb/tb_bilinear_texture_sampler_unit.sv =====
// Stimulus and verdict for the bilinear texture sampler.
module tb_bilinear_texture_sampler_unit;
  import bts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE = 2'd2;  // beyond the register list, ignored
  localparam int CYCLE_LIMIT = 2000000;
  localparam int NUM_SETTINGS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_WRITE;
  logic [ADDR_W-1:0] texel_index = '0;
  logic [COLOR_W-1:0] texel_red = '0, texel_green = '0, texel_blue = '0;
  logic texel_invalid = 1'b0;
  logic signed [COORD_W-1:0] u_coord = '0, v_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COLOR_W-1:0] red_out, green_out, blue_out;
  logic invalid_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  int fail_count, samples_due;
  int beats_sent = 0;
  int cycles = 0;
  bit idle_on = 1'b1;   // random gaps allowed in this phase
  bit calm = 1'b0;      // final stretch: no idling anywhere
  int rx_stall = 0;
  bit seeded [0:(1<<ADDR_W)-1];  // entries written so far; only these get read

  // (width, height) settings walked in order; oversize values saturate to 256
  int dim_w [NUM_SETTINGS] = '{0, 0, 5, 256, 1, 511, 16, 300, 2, 7};
  int dim_h [NUM_SETTINGS] = '{0, 5, 7, 1, 256, 2, 16, 1, 511, 0};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bilinear_texture_sampler_unit dut (.*);

  bts_checker scoreboard (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bilinear_texture_sampler_unit test failed");
      $finish;
    end
  end

  // Result side backpressure: random stall bursts.
  always @(posedge clk) begin
    if (rx_stall != 0) begin
      out_ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (!calm && idle_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      rx_stall <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One input beat; optional gap first, then hold valid until accepted.
  task automatic send_beat(logic op, logic [15:0] idx, logic [15:0] r, logic [15:0] g,
                           logic [15:0] b, logic bad, logic [19:0] u, logic [19:0] v);
    if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    opcode <= op; texel_index <= idx;
    texel_red <= r; texel_green <= g; texel_blue <= b; texel_invalid <= bad;
    u_coord <= u; v_coord <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_WRITE) seeded[idx] = 1'b1;
    beats_sent++;
  endtask

  task automatic put_texel(logic [15:0] idx, logic bad);
    send_beat(OP_WRITE, idx, 16'($urandom), 16'($urandom), 16'($urandom), bad,
              20'($urandom), 20'($urandom));
  endtask

  task automatic sample_at(logic [19:0] u, logic [19:0] v);
    send_beat(OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              1'($urandom), u, v);
  endtask

  // Coordinate mix: negatives, exact 0 and 1, above one, and in-range values.
  function automatic logic [19:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return {1'b1, 19'($urandom)};
      1: return '0;
      2: return 20'h10000;
      3: return 20'($urandom_range(65537, 524287));
      4: return 20'($urandom);
      default: return 20'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain the pipe; write beats produce nothing, so add the pipe depth on top.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int w, h, span, n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_SPARE, 9'h1FF);
    write_reg(2'd3, 9'h0AA);
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      idle_on = (s % 3 != 1);
      calm = (s == NUM_SETTINGS - 1);
      settle();
      write_reg(REG_WIDTH, DIM_W'(dim_w[s]));
      write_reg(REG_HEIGHT, DIM_W'(dim_h[s]));
      w = (dim_w[s] > MAX_DIM) ? MAX_DIM : dim_w[s];
      h = (dim_h[s] > MAX_DIM) ? MAX_DIM : dim_h[s];
      span = w * h;
      // every texel a sample may touch gets written first
      for (int a = 0; a < span; a++)
        if (!seeded[a]) put_texel(16'(a), $urandom_range(0, 15) == 0);
      if (s == 2) begin
        // directed: color extremes, an invalid texel, coordinate corners
        send_beat(OP_WRITE, 16'd0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, '0, '0);
        send_beat(OP_WRITE, 16'd4, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, '0, '0);
        send_beat(OP_WRITE, 16'd34, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0);
        send_beat(OP_WRITE, 16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC, 1'b1, '0, '0);
        send_beat(OP_WRITE, 16'd12, 16'h8000, 16'h8000, 16'h8000, 1'b1, '0, '0);
        sample_at(20'h00000, 20'h00000);
        sample_at(20'h10000, 20'h00000);
        sample_at(20'h10000, 20'h10000);
        sample_at(20'h80000, 20'h80000);
        sample_at(20'h7FFFF, 20'h7FFFF);
        sample_at(20'hFFFFF, 20'h10001);
        sample_at(20'h08000, 20'h08000);
        sample_at(20'h0C000, 20'h0AAAB);
        sample_at(20'h00001, 20'h0FFFF);
        sample_at(20'h4000, 20'h4000);  // grid next to the invalid texel, which it does not touch
        put_texel(16'd12, 1'b0);
        sample_at(20'h4000, 20'h4000);
      end
      n = (s == NUM_SETTINGS - 1) ? 120 : 145;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          // writes: mostly inside the live texture, some anywhere
          if (span != 0 && $urandom_range(0, 2) != 0)
            put_texel(16'($urandom_range(0, span - 1)), $urandom_range(0, 15) == 0);
          else
            put_texel(16'($urandom), $urandom_range(0, 15) == 0);
        end else begin
          sample_at(pick_coord(), pick_coord());
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d input beats over %0d width/height settings, spare indexes too.",
             beats_sent, NUM_SETTINGS);
    if (fail_count == 0)
      $display("bilinear_texture_sampler_unit test passed");
    else
      $display("bilinear_texture_sampler_unit test failed");
    $finish;
  end
endmodule
